FILE: design/quadrature_nco_assert.svh
// assertion macros for the quadrature oscillator
`ifndef QUADRATURE_NCO_ASSERT_SVH
`define QUADRATURE_NCO_ASSERT_SVH

// same-cycle implication
`define QNCO_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("quadrature_nco: same-cycle check failed");

// next-cycle implication
`define QNCO_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("quadrature_nco: next-cycle check failed");

`endif

FILE: design/qnco_pkg.sv
package qnco_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int OUT_BITS      = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int ATAN_ENTRIES  = 24;
    localparam int N_CELLS       = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    // x and y in q2.30 plus headroom
    localparam int XW            = 34;
    localparam int PW            = PHASE_BITS + 32;
    localparam logic [XW-1:0] GAIN_Q30 = XW'(652032874);

    localparam int OUT_SH        = 31 - OUT_BITS;
    localparam int OUT_RND       = 1 << (OUT_SH - 1);
    localparam int OUT_LIM       = (1 << (OUT_BITS - 1)) - 1;

    localparam logic [2:0] FUNC_ADVANCE   = 3'd0;
    localparam logic [2:0] FUNC_PEEK      = 3'd1;
    localparam logic [2:0] FUNC_LOAD_PH   = 3'd2;
    localparam logic [2:0] FUNC_LOAD_FREQ = 3'd3;
    localparam logic [2:0] FUNC_ADD_FREQ  = 3'd4;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [31:0]   z;
        logic          flip;
        logic [31:0]   freq;
    } t_cordic;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/qnco_cell.sv
module qnco_cell import qnco_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_shift,
    input  logic [31:0] i_atan,
    input  logic        i_valid,
    input  t_cordic     i_data,
    output logic        o_ready,
    output logic        o_valid,
    output t_cordic     o_data,
    input  logic        i_ready
);

    logic           r_valid;
    t_cordic        r_data;
    t_cordic        n_data;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_x  = $signed(i_data.x);
    assign w_y  = $signed(i_data.y);
    assign w_xs = w_x >>> i_shift;
    assign w_ys = w_y >>> i_shift;

    always_comb begin
        n_data = i_data;
        if (!i_data.z[31]) begin
            n_data.x = w_x - w_ys;
            n_data.y = w_y + w_xs;
            n_data.z = i_data.z - i_atan;
        end else begin
            n_data.x = w_x + w_ys;
            n_data.y = w_y - w_xs;
            n_data.z = i_data.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: design/qnco_out.sv
module qnco_out import qnco_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_cordic             i_data,
    output logic                o_ready,
    output logic                o_valid,
    output logic [OUT_BITS-1:0] o_i_out,
    output logic [OUT_BITS-1:0] o_q_out,
    output logic [31:0]         o_freq_word,
    input  logic                i_ready
);

    localparam logic signed [XW-1:0] C_RND = XW'(OUT_RND);
    localparam logic signed [XW-1:0] C_LIM = XW'(OUT_LIM);

    logic                r_valid;
    logic [OUT_BITS-1:0] r_i;
    logic [OUT_BITS-1:0] r_q;
    logic [31:0]         r_freq;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;

    function automatic logic [OUT_BITS-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + C_RND) >>> OUT_SH;
        if (r > C_LIM) begin
            r = C_LIM;
        end else if (r < -C_LIM) begin
            r = -C_LIM;
        end
        return OUT_BITS'(r);
    endfunction

    assign w_x = i_data.flip ? -$signed(i_data.x) : $signed(i_data.x);
    assign w_y = i_data.flip ? -$signed(i_data.y) : $signed(i_data.y);

    assign o_ready     = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_i_out     = r_i;
    assign o_q_out     = r_q;
    assign o_freq_word = r_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_i    <= round_sat(w_x);
            r_q    <= round_sat(w_y);
            r_freq <= i_data.freq;
        end
    end

endmodule

FILE: design/quadrature_nco.sv
// channel | valid   | ready   | payload
// input   | i_valid | o_ready | i_func, i_value
// output  | o_valid | i_ready | o_i_out, o_q_out, o_freq_word
//
// one transaction per cycle sustained while i_ready holds; the stages are the phase stage,
// one per cordic cell (CORDIC_STAGES, at most 24) and the rounding stage
// each stage holds its own valid bit, so bubbles close up under an output stall
// and the input is refused only when every stage holds a transaction
// synchronous reset clears phase, frequency and all valid bits; no clearing pass
`include "quadrature_nco_assert.svh"

module quadrature_nco import qnco_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_func,
    input  logic [31:0]         i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_BITS-1:0] o_i_out,
    output logic [OUT_BITS-1:0] o_q_out,
    output logic [31:0]         o_freq_word
);

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [31:0]           r_step;
    logic [31:0]           n_step;
    logic [PHASE_BITS-1:0] w_emit;
    logic [PW-1:0]         w_ext;
    logic [31:0]           w_z;
    logic                  w_flip;
    logic                  w_accept;

    t_cordic               w_c   [N_CELLS+1];
    logic                  w_v   [N_CELLS+1];
    logic                  w_rdy [N_CELLS+1];
    logic [N_CELLS:0]      w_vv;
    logic                  w_out_rdy;

    logic                  r_front_v;
    t_cordic               r_front;

    assign o_ready  = !r_front_v || w_rdy[0];
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        w_emit  = r_phase;
        case (i_func)
            FUNC_ADVANCE: begin
                n_phase = PHASE_BITS'(PW'(r_phase) + PW'($signed(r_step)));
            end
            FUNC_LOAD_PH: begin
                n_phase = PHASE_BITS'(PW'($signed(i_value)));
                w_emit  = n_phase;
            end
            FUNC_LOAD_FREQ: begin
                n_step = i_value;
            end
            FUNC_ADD_FREQ: begin
                n_step = r_step + i_value;
            end
            default: begin
            end
        endcase
    end

    // phase brought to 32 bits per turn, then folded into the right half-plane
    assign w_ext  = {w_emit, 32'd0};
    assign w_z    = w_ext[PW-1 -: 32];
    assign w_flip = w_z[31] ^ w_z[30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_front_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_step  <= n_step;
            end
            if (o_ready) begin
                r_front_v <= i_valid;
            end
        end
        if (w_accept) begin
            r_front.x    <= GAIN_Q30;
            r_front.y    <= '0;
            r_front.z    <= {w_z[31] ^ w_flip, w_z[30:0]};
            r_front.flip <= w_flip;
            r_front.freq <= n_step;
        end
    end

    assign w_c[0] = r_front;
    assign w_v[0] = r_front_v;
    assign w_rdy[N_CELLS] = w_out_rdy;

    genvar g;
    generate
        for (g = 0; g < N_CELLS; g++) begin : g_cell
            qnco_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (5'(g)),
                .i_atan  (atan_turn(5'(g))),
                .i_valid (w_v[g]),
                .i_data  (w_c[g]),
                .o_ready (w_rdy[g]),
                .o_valid (w_v[g+1]),
                .o_data  (w_c[g+1]),
                .i_ready (w_rdy[g+1])
            );
        end
        for (g = 0; g <= N_CELLS; g++) begin : g_vv
            assign w_vv[g] = w_v[g];
        end
    endgenerate

    qnco_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[N_CELLS]),
        .i_data      (w_c[N_CELLS]),
        .o_ready     (w_out_rdy),
        .o_valid     (o_valid),
        .o_i_out     (o_i_out),
        .o_q_out     (o_q_out),
        .o_freq_word (o_freq_word),
        .i_ready     (i_ready)
    );

    `QNCO_ASSERT_NXT(a_load_freq, i_clk, i_rst_n,
        w_accept && (i_func == FUNC_LOAD_FREQ), r_step == $past(i_value))
    `QNCO_ASSERT_NXT(a_peek_holds, i_clk, i_rst_n,
        w_accept && (i_func == FUNC_PEEK), r_phase == $past(r_phase))
    `QNCO_ASSERT_IMP(a_full_stall, i_clk, i_rst_n,
        !o_ready, (&w_vv) && o_valid && !i_ready)

endmodule
